@@ src/ovsf_pkg.sv @@
// shared types, constants and crc helper for the velocity shaper and framer
`default_nettype none

package ovsf_pkg;

    localparam int FRAC_BITS = 8;
    localparam int VEL_W     = 16;
    localparam int SMOOTH_W  = VEL_W + FRAC_BITS;
    localparam int LIM_W     = 15;
    localparam int WGT_W     = 8;
    localparam int TOUT_W    = 16;
    localparam int THR_W     = 10;
    localparam int CMD_W     = 2;
    localparam int CFG_AW    = 3;
    localparam int CFG_DW    = 16;
    localparam int BYTE_W    = 8;
    localparam int POS_W     = 4;

    // filter products and their sum
    localparam int PROD_W = SMOOTH_W + WGT_W + 2;
    localparam int SUM_W  = PROD_W + 1;

    localparam logic [LIM_W-1:0]  LIMIT_X_RST  = LIM_W'(1000);
    localparam logic [LIM_W-1:0]  LIMIT_Y_RST  = LIM_W'(1000);
    localparam logic [LIM_W-1:0]  LIMIT_R_RST  = LIM_W'(2000);
    localparam logic [WGT_W-1:0]  WEIGHT_RST   = WGT_W'(179);
    localparam logic [TOUT_W-1:0] TIMEOUT_RST  = TOUT_W'(10);
    localparam logic [THR_W-1:0]  THRESH_RST   = THR_W'(10);

    localparam logic [BYTE_W-1:0] BYTE_SYNC0 = 8'hAA;
    localparam logic [BYTE_W-1:0] BYTE_SYNC1 = 8'h55;
    localparam logic [BYTE_W-1:0] BYTE_LEN   = 8'h10;
    localparam logic [BYTE_W-1:0] BYTE_END   = 8'h0D;
    localparam logic [15:0]       CRC_INIT   = 16'hFFFF;
    localparam logic [15:0]       CRC_POLY   = 16'hA001;

    // byte positions within the frame
    localparam logic [POS_W-1:0] POS_SYNC0  = 4'd0;
    localparam logic [POS_W-1:0] POS_SYNC1  = 4'd1;
    localparam logic [POS_W-1:0] POS_LEN    = 4'd2;
    localparam logic [POS_W-1:0] POS_X_LO   = 4'd3;
    localparam logic [POS_W-1:0] POS_X_HI   = 4'd4;
    localparam logic [POS_W-1:0] POS_Y_LO   = 4'd5;
    localparam logic [POS_W-1:0] POS_Y_HI   = 4'd6;
    localparam logic [POS_W-1:0] POS_R_LO   = 4'd7;
    localparam logic [POS_W-1:0] POS_R_HI   = 4'd8;
    localparam logic [POS_W-1:0] POS_PAD0   = 4'd9;
    localparam logic [POS_W-1:0] POS_PAD1   = 4'd10;
    localparam logic [POS_W-1:0] POS_PAD2   = 4'd11;
    localparam logic [POS_W-1:0] POS_CRC_LO = 4'd12;
    localparam logic [POS_W-1:0] POS_CRC_HI = 4'd13;
    localparam logic [POS_W-1:0] POS_END    = 4'd14;

    typedef enum logic [CMD_W-1:0] {
        CMD_VEL  = 2'd0,
        CMD_TICK = 2'd1,
        CMD_STOP = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ACT_HOLD   = 2'd0,
        ACT_SMOOTH = 2'd1,
        ACT_DECAY  = 2'd2,
        ACT_ZERO   = 2'd3
    } act_t;

    typedef enum logic [CFG_AW-1:0] {
        REG_LIMIT_X  = 3'd0,
        REG_LIMIT_Y  = 3'd1,
        REG_LIMIT_R  = 3'd2,
        REG_WEIGHT   = 3'd3,
        REG_TIMEOUT  = 3'd4,
        REG_LAT_EN   = 3'd5,
        REG_STOP_THR = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic capture;
        logic mul_en;
        logic commit;
        act_t act;
    } lane_ctrl_t;

    typedef struct packed {
        logic above;
    } lane_stat_t;

    typedef struct packed {
        logic signed [SMOOTH_W-1:0] x;
        logic signed [SMOOTH_W-1:0] y;
        logic signed [SMOOTH_W-1:0] rot;
    } frame_vals_t;

    typedef struct packed {
        act_t act;
        logic send;
    } merge_out_t;

    // one byte of modbus crc-16, lsb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [BYTE_W-1:0] data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < BYTE_W; b++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ src/ovsf_lane.sv @@
// one axis lane: clamp, first-order filter, decay and threshold test
`default_nettype none

module ovsf_lane
    import ovsf_pkg::*;
(
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire lane_ctrl_t                 ctrl,
    input  wire logic signed [VEL_W-1:0]    vel_in,
    input  wire logic        [LIM_W-1:0]    limit,
    input  wire logic                       enable,
    input  wire logic        [WGT_W-1:0]    weight,
    input  wire logic        [THR_W-1:0]    thresh,
    output lane_stat_t                      stat,
    output logic signed [SMOOTH_W-1:0]      smooth_next
);

    logic signed [SMOOTH_W-1:0] smooth_reg;
    logic signed [VEL_W-1:0]    vclamp_reg, vclamp_next;
    logic signed [PROD_W-1:0]   prod_old_reg, prod_new_reg;
    logic signed [PROD_W-1:0]   prod_old_next, prod_new_next;
    logic        [SMOOTH_W-1:0] half_reg, half_next;
    logic                       above_reg, above_next;

    logic signed [VEL_W:0]      v_ext, l_ext, nl_ext;
    logic signed [WGT_W+1:0]    w_old, w_new;
    logic signed [SMOOTH_W-1:0] vf;
    logic        [SMOOTH_W-1:0] thr_f, mag_old, mag_half, half_tmp;
    logic signed [SUM_W-1:0]    sum, biased;
    logic signed [SMOOTH_W-1:0] filt;
    logic                       half_below;

    // clamp to the symmetric limit, or zero when the lane is disabled
    always_comb begin
        v_ext  = (VEL_W+1)'(vel_in);
        l_ext  = $signed({2'b00, limit});
        nl_ext = -l_ext;
        if (!enable) begin
            vclamp_next = '0;
        end else if (v_ext > l_ext) begin
            vclamp_next = VEL_W'(l_ext);
        end else if (v_ext < nl_ext) begin
            vclamp_next = VEL_W'(nl_ext);
        end else begin
            vclamp_next = vel_in;
        end
    end

    // products, halving and threshold compare on the stored value
    always_comb begin
        w_old         = $signed({2'b00, weight});
        w_new         = $signed((WGT_W+2)'(1 << WGT_W)) - w_old;
        vf            = {vclamp_reg, {FRAC_BITS{1'b0}}};
        prod_old_next = PROD_W'(w_old) * PROD_W'(smooth_reg);
        prod_new_next = PROD_W'(w_new) * PROD_W'(vf);
        thr_f         = SMOOTH_W'({thresh, {FRAC_BITS{1'b0}}});
        mag_old       = smooth_reg[SMOOTH_W-1] ? SMOOTH_W'(-smooth_reg)
                                               : SMOOTH_W'(smooth_reg);
        above_next    = mag_old > thr_f;
        half_tmp      = smooth_reg + SMOOTH_W'(smooth_reg[SMOOTH_W-1]);
        half_next     = {half_tmp[SMOOTH_W-1], half_tmp[SMOOTH_W-1:1]};
    end

    // sum, divide by 256 toward zero, pick the new value
    always_comb begin
        sum        = SUM_W'(prod_old_reg) + SUM_W'(prod_new_reg);
        biased     = sum + $signed(SUM_W'({WGT_W{sum[SUM_W-1]}}));
        filt       = biased[WGT_W +: SMOOTH_W];
        mag_half   = half_reg[SMOOTH_W-1] ? -half_reg : half_reg;
        half_below = mag_half < thr_f;
        case (ctrl.act)
            ACT_SMOOTH: smooth_next = filt;
            ACT_DECAY:  smooth_next = half_below ? '0 : $signed(half_reg);
            ACT_ZERO:   smooth_next = '0;
            default:    smooth_next = smooth_reg;
        endcase
    end

    assign stat.above = above_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            smooth_reg <= '0;
        end else if (ctrl.commit) begin
            smooth_reg <= smooth_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.capture) begin
            vclamp_reg <= vclamp_next;
        end
        if (ctrl.mul_en) begin
            prod_old_reg <= prod_old_next;
            prod_new_reg <= prod_new_next;
            half_reg     <= half_next;
            above_reg    <= above_next;
        end
    end

endmodule

`default_nettype wire

@@ src/ovsf_merge.sv @@
// merges lane findings with idle count and stop flag into one action
`default_nettype none

module ovsf_merge
    import ovsf_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire cmd_t                cmd,
    input  wire lane_stat_t          stat_x,
    input  wire lane_stat_t          stat_y,
    input  wire lane_stat_t          stat_rot,
    input  wire logic [TOUT_W-1:0]   timeout,
    input  wire logic                commit,
    output merge_out_t               dec
);

    logic [TOUT_W-1:0] idle_reg, idle_next;
    logic              stopped_reg, stopped_next;
    logic [TOUT_W-1:0] idle_inc;
    logic              any_above;

    always_comb begin
        any_above    = stat_x.above | stat_y.above | stat_rot.above;
        idle_inc     = (&idle_reg) ? idle_reg : idle_reg + TOUT_W'(1);
        idle_next    = idle_reg;
        stopped_next = stopped_reg;
        dec.act      = ACT_HOLD;
        dec.send     = 1'b0;
        unique case (cmd)
            CMD_VEL: begin
                idle_next    = '0;
                stopped_next = 1'b0;
                dec.act      = ACT_SMOOTH;
                dec.send     = 1'b1;
            end
            CMD_TICK: begin
                if (!stopped_reg) begin
                    idle_next = idle_inc;
                    if (idle_inc > timeout && any_above) begin
                        dec.act  = ACT_DECAY;
                        dec.send = 1'b1;
                    end
                end
            end
            CMD_STOP: begin
                stopped_next = 1'b1;
                dec.act      = ACT_ZERO;
                dec.send     = 1'b1;
            end
            default: begin
                dec.act  = ACT_HOLD;
                dec.send = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idle_reg    <= '0;
            stopped_reg <= 1'b0;
        end else if (commit) begin
            idle_reg    <= idle_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule

`default_nettype wire

@@ src/ovsf_framer.sv @@
// frame serialiser with running modbus crc, one byte per cycle while m_tready is high
`default_nettype none

module ovsf_framer
    import ovsf_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 load,
    input  wire frame_vals_t          vals,
    output logic                      free,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [BYTE_W-1:0]         m_tdata,
    output logic                      m_tlast
);

    logic              busy_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [15:0]       crc_reg;
    frame_vals_t       vals_reg;

    logic [15:0]       wx, wy, wr;
    logic [BYTE_W-1:0] cur;
    logic              fire;

    // truncate toward zero to whole units
    function automatic logic [15:0] to_word(input logic [SMOOTH_W-1:0] v);
        logic [SMOOTH_W-1:0] t;
        t = v + SMOOTH_W'({FRAC_BITS{v[SMOOTH_W-1]}});
        return t[FRAC_BITS +: 16];
    endfunction

    always_comb begin
        wx = to_word(vals_reg.x);
        wy = to_word(vals_reg.y);
        wr = to_word(vals_reg.rot);
        case (pos_reg)
            POS_SYNC0:  cur = BYTE_SYNC0;
            POS_SYNC1:  cur = BYTE_SYNC1;
            POS_LEN:    cur = BYTE_LEN;
            POS_X_LO:   cur = wx[7:0];
            POS_X_HI:   cur = wx[15:8];
            POS_Y_LO:   cur = wy[7:0];
            POS_Y_HI:   cur = wy[15:8];
            POS_R_LO:   cur = wr[7:0];
            POS_R_HI:   cur = wr[15:8];
            POS_CRC_LO: cur = crc_reg[7:0];
            POS_CRC_HI: cur = crc_reg[15:8];
            POS_END:    cur = BYTE_END;
            default:    cur = '0;
        endcase
    end

    assign m_tvalid = busy_reg;
    assign m_tdata  = cur;
    assign m_tlast  = (pos_reg == POS_END);
    assign fire     = busy_reg & m_tready;
    assign free     = !busy_reg || (fire && m_tlast);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pos_reg  <= POS_SYNC0;
        end else if (load) begin
            busy_reg <= 1'b1;
            pos_reg  <= POS_SYNC0;
        end else if (fire) begin
            if (m_tlast) begin
                busy_reg <= 1'b0;
            end
            pos_reg <= pos_reg + POS_W'(1);
        end
    end

    // crc covers everything ahead of the crc bytes
    always_ff @(posedge aclk) begin
        if (load) begin
            vals_reg <= vals;
            crc_reg  <= CRC_INIT;
        end else if (fire && pos_reg < POS_CRC_LO) begin
            crc_reg <= crc_byte(crc_reg, cur);
        end
    end

endmodule

`default_nettype wire

@@ src/omni_velocity_shaper_framer.sv @@
// top level: velocity shaper with three axis lanes and serial frame output
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+-------------------------------------
//  s_       | in        | s_tvalid / s_tready     | tuser: cmd; tdata: vel_x, vel_y, vel_rot
//  m_       | out       | m_tvalid / m_tready     | tdata: frame_byte; tlast: last
//  cfg_     | in        | cfg_wr_en (no back-pressure) | cfg_addr, cfg_wdata
//
//  an item passes the lane stages in order (capture and clamp, multiply, sum and commit)
//  a frame leaves at one byte per cycle while m_tready is high; the next item is taken
//  while a frame is still going out
//  a finished item holds in the commit stage until the serialiser can load its frame
//  reset is synchronous, active low, and clears filter state, idle count and stop flag
`default_nettype none

module omni_velocity_shaper_framer
    import ovsf_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // input items
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [47:0]       s_tdata,   // vel_x [15:0], vel_y [31:16], vel_rot [47:32]
    input  wire logic [7:0]        s_tuser,   // cmd [1:0], rest zero
    // frame bytes
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [7:0]             m_tdata,   // frame_byte [7:0]
    output logic                   m_tlast,
    // configuration writes
    input  wire logic              cfg_wr_en,
    input  wire logic [CFG_AW-1:0] cfg_addr,
    input  wire logic [CFG_DW-1:0] cfg_wdata
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MUL  = 3'b010,
        ST_SUM  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [LIM_W-1:0]  limit_x_reg, limit_y_reg, limit_rot_reg;
    logic [WGT_W-1:0]  weight_reg;
    logic [TOUT_W-1:0] timeout_reg;
    logic              lat_en_reg;
    logic [THR_W-1:0]  thresh_reg;

    cmd_t         cmd_reg;
    lane_ctrl_t   ctrl;
    lane_stat_t   stat_x, stat_y, stat_rot;
    merge_out_t   dec;
    frame_vals_t  vals;
    logic         accept, frame_free, frame_load;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid & s_tready;

    // sequencer through the lane stages
    always_comb begin
        state_next   = state_reg;
        ctrl.capture = 1'b0;
        ctrl.mul_en  = 1'b0;
        ctrl.commit  = 1'b0;
        ctrl.act     = dec.act;
        frame_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                ctrl.capture = accept;
                if (accept) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                ctrl.mul_en = 1'b1;
                state_next  = ST_SUM;
            end
            ST_SUM: begin
                // hold here until the serialiser can take the frame
                if (!dec.send || frame_free) begin
                    ctrl.commit = 1'b1;
                    frame_load  = dec.send;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg <= cmd_t'(s_tuser[CMD_W-1:0]);
        end
    end

    // register writes, an index past the list is dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_x_reg   <= LIMIT_X_RST;
            limit_y_reg   <= LIMIT_Y_RST;
            limit_rot_reg <= LIMIT_R_RST;
            weight_reg    <= WEIGHT_RST;
            timeout_reg   <= TIMEOUT_RST;
            lat_en_reg    <= 1'b1;
            thresh_reg    <= THRESH_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_LIMIT_X:  limit_x_reg   <= cfg_wdata[LIM_W-1:0];
                REG_LIMIT_Y:  limit_y_reg   <= cfg_wdata[LIM_W-1:0];
                REG_LIMIT_R:  limit_rot_reg <= cfg_wdata[LIM_W-1:0];
                REG_WEIGHT:   weight_reg    <= cfg_wdata[WGT_W-1:0];
                REG_TIMEOUT:  timeout_reg   <= cfg_wdata[TOUT_W-1:0];
                REG_LAT_EN:   lat_en_reg    <= cfg_wdata[0];
                REG_STOP_THR: thresh_reg    <= cfg_wdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // forward axis lane
    ovsf_lane u_lane_x (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .vel_in      ($signed(s_tdata[15:0])),
        .limit       (limit_x_reg),
        .enable      (1'b1),
        .weight      (weight_reg),
        .thresh      (thresh_reg),
        .stat        (stat_x),
        .smooth_next (vals.x)
    );

    // lateral lane, gated by the enable register
    ovsf_lane u_lane_y (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .vel_in      ($signed(s_tdata[31:16])),
        .limit       (limit_y_reg),
        .enable      (lat_en_reg),
        .weight      (weight_reg),
        .thresh      (thresh_reg),
        .stat        (stat_y),
        .smooth_next (vals.y)
    );

    // rotation lane
    ovsf_lane u_lane_rot (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .vel_in      ($signed(s_tdata[47:32])),
        .limit       (limit_rot_reg),
        .enable      (1'b1),
        .weight      (weight_reg),
        .thresh      (thresh_reg),
        .stat        (stat_rot),
        .smooth_next (vals.rot)
    );

    // decides the action from the lanes, idle count and stop flag
    ovsf_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd_reg),
        .stat_x   (stat_x),
        .stat_y   (stat_y),
        .stat_rot (stat_rot),
        .timeout  (timeout_reg),
        .commit   (ctrl.commit),
        .dec      (dec)
    );

    // serialiser, loaded with the values just committed
    ovsf_framer u_framer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (frame_load),
        .vals     (vals),
        .free     (frame_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

@@ tb/sv/omni_velocity_shaper_framer_tb.sv @@
// self-checking testbench for the omni velocity shaper and serial framer
`timescale 1ns / 100ps

module omni_velocity_shaper_framer_tb;
    import ovsf_pkg::*;

    // run shape
    localparam int          RANDOM_ITEMS  = 300;
    localparam int          SETTLE_CYCLES = 24;         // lanes plus a whole frame
    localparam int          LIMIT_CYCLES  = 1_500_000;  // far above a fully stalled run
    localparam int          FRAME_LEN     = 15;
    localparam int unsigned IDLE_MAX      = 65535;
    localparam longint      UNIT          = longint'(1) << FRAC_BITS;
    localparam longint      WEIGHT_ONE    = 256;        // smoothing factor is q0.8

    // the one command code the block has no use for
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [BYTE_W-1:0] value;
        logic              last;
    } frame_byte_t;

    // ports
    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [47:0]       s_tdata   = '0;   // vel_x [15:0], vel_y [31:16], vel_rot [47:32]
    logic [7:0]        s_tuser   = '0;   // cmd [1:0], rest zero
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [7:0]        m_tdata;          // frame_byte [7:0]
    logic              m_tlast;
    logic              cfg_wr_en = 1'b0;
    cfg_idx_t          cfg_addr  = REG_LIMIT_X;
    logic [CFG_DW-1:0] cfg_wdata = '0;

    // register mirror, starts at the reset values
    int unsigned cfg_limit_x  = LIMIT_X_RST;
    int unsigned cfg_limit_y  = LIMIT_Y_RST;
    int unsigned cfg_limit_r  = LIMIT_R_RST;
    int unsigned cfg_weight   = WEIGHT_RST;
    int unsigned cfg_timeout  = TIMEOUT_RST;
    int unsigned cfg_lat_en   = 1;
    int unsigned cfg_stop_thr = THRESH_RST;

    // shaper state as the block should hold it
    longint      axis_x     = 0;
    longint      axis_y     = 0;
    longint      axis_rot   = 0;
    int unsigned idle_ticks = 0;
    bit          estop      = 1'b0;

    frame_byte_t expected_bytes[$];
    int          mismatches  = 0;
    int          cycle_count = 0;

    // sender burst state
    int burst_left = 0;

    // receiver stall pattern
    logic [9:0] rx_phase = '0;
    int         rx_hold  = 0;

    omni_velocity_shaper_framer DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic longint abs_val(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint clamp_axis(input longint v, input int unsigned lim);
        longint l;
        l = longint'(lim);
        if (v > l) return l;
        if (v < -l) return -l;
        return v;
    endfunction

    // first-order filter, the division truncates toward zero
    function automatic longint filter_axis(input longint s, input longint v);
        longint w;
        w = longint'(cfg_weight);
        return (w * s + (WEIGHT_ONE - w) * (v * UNIT)) / WEIGHT_ONE;
    endfunction

    // builds the 15-byte frame from the current axes and queues it
    function automatic void push_frame();
        logic [BYTE_W-1:0] fb [FRAME_LEN];
        logic [15:0]       vx;
        logic [15:0]       vy;
        logic [15:0]       vr;
        logic [15:0]       crc;
        frame_byte_t       e;
        // whole units, truncated toward zero
        vx = 16'(axis_x / UNIT);
        vy = 16'(axis_y / UNIT);
        vr = 16'(axis_rot / UNIT);
        fb[POS_SYNC0]  = BYTE_SYNC0;
        fb[POS_SYNC1]  = BYTE_SYNC1;
        fb[POS_LEN]    = BYTE_LEN;
        fb[POS_X_LO]   = vx[7:0];
        fb[POS_X_HI]   = vx[15:8];
        fb[POS_Y_LO]   = vy[7:0];
        fb[POS_Y_HI]   = vy[15:8];
        fb[POS_R_LO]   = vr[7:0];
        fb[POS_R_HI]   = vr[15:8];
        fb[POS_PAD0]   = 8'h00;
        fb[POS_PAD1]   = 8'h00;
        fb[POS_PAD2]   = 8'h00;
        // modbus crc over everything before the crc itself, lsb first
        crc = CRC_INIT;
        for (int i = 0; i < int'(POS_CRC_LO); i++) begin
            crc = crc ^ {8'h00, fb[i]};
            for (int b = 0; b < BYTE_W; b++) begin
                crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
            end
        end
        fb[POS_CRC_LO] = crc[7:0];
        fb[POS_CRC_HI] = crc[15:8];
        fb[POS_END]    = BYTE_END;
        for (int i = 0; i < FRAME_LEN; i++) begin
            e.value = fb[i];
            e.last  = (i == int'(POS_END));
            expected_bytes.insert(expected_bytes.size(), e);
        end
    endfunction

    // state update for one accepted item, queues whatever frame it causes
    function automatic void shape_command(input logic [CMD_W-1:0] op,
                                          input logic [VEL_W-1:0] vx,
                                          input logic [VEL_W-1:0] vy,
                                          input logic [VEL_W-1:0] vr);
        longint thr;
        longint cy;
        thr = longint'(cfg_stop_thr) * UNIT;
        case (op)
            CMD_VEL: begin
                cy         = cfg_lat_en ? clamp_axis(longint'($signed(vy)), cfg_limit_y) : 0;
                idle_ticks = 0;
                estop      = 1'b0;
                axis_x     = filter_axis(axis_x, clamp_axis(longint'($signed(vx)), cfg_limit_x));
                axis_y     = filter_axis(axis_y, cy);
                axis_rot   = filter_axis(axis_rot, clamp_axis(longint'($signed(vr)), cfg_limit_r));
                push_frame();
            end
            CMD_TICK: begin
                // a stopped block ignores ticks altogether
                if (!estop) begin
                    if (idle_ticks < IDLE_MAX) idle_ticks++;
                    if (idle_ticks > cfg_timeout &&
                        (abs_val(axis_x) > thr || abs_val(axis_y) > thr ||
                         abs_val(axis_rot) > thr)) begin
                        axis_x   = axis_x / 2;
                        axis_y   = axis_y / 2;
                        axis_rot = axis_rot / 2;
                        if (abs_val(axis_x) < thr) axis_x = 0;
                        if (abs_val(axis_y) < thr) axis_y = 0;
                        if (abs_val(axis_rot) < thr) axis_rot = 0;
                        push_frame();
                    end
                end
            end
            CMD_STOP: begin
                // idle count is left alone
                estop    = 1'b1;
                axis_x   = 0;
                axis_y   = 0;
                axis_rot = 0;
                push_frame();
            end
            default: begin
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    // receiver: always ready, light random stalls, ready again, long stall bursts
    always @(posedge aclk) begin
        rx_phase <= rx_phase + 1'b1;
        case (rx_phase[9:8])
            2'd1: begin
                m_tready <= ($urandom_range(0, 3) != 0);
            end
            2'd3: begin
                if (rx_hold != 0) begin
                    rx_hold  <= rx_hold - 1;
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                    if ($urandom_range(0, 5) == 0) rx_hold <= $urandom_range(1, 12);
                end
            end
            default: begin
                m_tready <= 1'b1;
            end
        endcase
    end

    // outputs are steady between the falling edge and the accepting rising edge,
    // so the byte is checked on the falling edge before the handshake
    always @(negedge aclk) begin : frame_check
        frame_byte_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (expected_bytes.size() == 0) begin
                if (mismatches < 10) begin
                    $display("unexpected frame byte %02h last %0b", m_tdata, m_tlast);
                end
                mismatches++;
            end else begin
                want = expected_bytes.pop_front();
                if (m_tdata !== want.value || m_tlast !== want.last) begin
                    if (mismatches < 10) begin
                        $display("frame byte mismatch: expected %02h last %0b, got %02h last %0b",
                                 want.value, want.last, m_tdata, m_tlast);
                    end
                    mismatches++;
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("omni_velocity_shaper_framer_tb: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // sends one item; entered and left on a rising edge
    task automatic send_item(input logic [CMD_W-1:0] op, input logic [VEL_W-1:0] vx,
                             input logic [VEL_W-1:0] vy, input logic [VEL_W-1:0] vr);
        int gap;
        bit taken;
        // bursts of random length, random gaps between them
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        if (burst_left > 0) burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= 8'(op);
        s_tdata  <= {vr, vy, vx};
        // ready looked at on the falling edge, taken on the next rising one
        do begin
            @(negedge aclk);
            taken = s_tready;
            @(posedge aclk);
        end while (!taken);
        shape_command(op, vx, vy, vr);
    endtask

    // lets every expected byte arrive, then the lanes settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input int unsigned value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value[CFG_DW-1:0];
        @(posedge aclk);
        case (idx)
            REG_LIMIT_X:  cfg_limit_x  = value & 32'h7FFF;
            REG_LIMIT_Y:  cfg_limit_y  = value & 32'h7FFF;
            REG_LIMIT_R:  cfg_limit_r  = value & 32'h7FFF;
            REG_WEIGHT:   cfg_weight   = value & 32'hFF;
            REG_TIMEOUT:  cfg_timeout  = value & 32'hFFFF;
            REG_LAT_EN:   cfg_lat_en   = value & 32'h1;
            REG_STOP_THR: cfg_stop_thr = value & 32'h3FF;
            default: begin
            end
        endcase
    endtask

    // writes every register back to back, only while the block is idle
    task automatic apply_config(input int unsigned lx, input int unsigned ly,
                                input int unsigned lr, input int unsigned w,
                                input int unsigned tout, input int unsigned lat,
                                input int unsigned thr);
        write_reg(REG_LIMIT_X, lx);
        write_reg(REG_LIMIT_Y, ly);
        write_reg(REG_LIMIT_R, lr);
        write_reg(REG_WEIGHT, w);
        write_reg(REG_TIMEOUT, tout);
        write_reg(REG_LAT_EN, lat);
        write_reg(REG_STOP_THR, thr);
        cfg_wr_en <= 1'b0;
    endtask

    // mostly near the current limit so clamping is hit from both sides
    function automatic logic [VEL_W-1:0] rand_vel(input int unsigned lim);
        int span;
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2: return 16'($urandom());
            3:       return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
            default: begin
                span = int'(lim) + int'(lim) / 4 + 2;
                v    = int'($urandom_range(0, 2 * span)) - span;
                if (v > 32767) v = 32767;
                if (v < -32768) v = -32768;
                return 16'(v);
            end
        endcase
    endfunction

    // register value: zero or top now and then, else something ordinary
    function automatic int unsigned pick_setting(input int unsigned top,
                                                 input int unsigned usual);
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return top;
            default: return $urandom_range(0, usual);
        endcase
    endfunction

    // a well-formed sequence: a few commands, then idle ticks into the decay
    task automatic vel_then_ticks(input int nv, input int nt);
        repeat (nv) begin
            send_item(CMD_VEL, rand_vel(cfg_limit_x), rand_vel(cfg_limit_y),
                      rand_vel(cfg_limit_r));
        end
        repeat (nt) send_item(CMD_TICK, 16'($urandom()), 16'($urandom()), 16'($urandom()));
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset settings: clamping, unused code, stop and ticks while stopped
    task automatic test_directed_edges();
        send_item(CMD_VEL, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_item(CMD_VEL, 16'h8000, 16'h8000, 16'h8000);
        send_item(CMD_VEL, 16'd0, 16'd0, 16'd0);
        send_item(CMD_VEL, 16'sd1000, -16'sd1000, 16'sd2000);
        send_item(CMD_VEL, 16'sd1001, -16'sd1001, -16'sd2001);
        send_item(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(CMD_STOP, 16'hFFFF, 16'h0000, 16'h5555);
        send_item(CMD_TICK, 16'h0000, 16'hFFFF, 16'hAAAA);
        send_item(CMD_TICK, 16'h1234, 16'h5678, 16'h9ABC);
        // small values: negative fractions must truncate toward zero
        send_item(CMD_VEL, 16'sd1, -16'sd1, 16'sd1);
        send_item(CMD_VEL, -16'sd3, 16'sd2, -16'sd7);
        // ticks still within the timeout give nothing
        repeat (3) send_item(CMD_TICK, 16'd0, 16'd0, 16'd0);
        send_item(CMD_STOP, 16'd0, 16'd0, 16'd0);
        wait_idle();
    endtask

    // no smoothing, no timeout: halving, zeroing below and holding at the threshold
    task automatic test_decay_and_threshold();
        apply_config(1000, 1000, 2000, 0, 0, 1, 10);
        send_item(CMD_VEL, 16'sd100, -16'sd100, 16'sd21);
        // rot drops out first, then x and y, then a quiet tick
        repeat (5) send_item(CMD_TICK, 16'd0, 16'd0, 16'd0);
        // halving lands exactly on the threshold and stays there
        send_item(CMD_VEL, 16'sd20, -16'sd20, 16'sd0);
        repeat (2) send_item(CMD_TICK, 16'd0, 16'd0, 16'd0);
        // a stop freezes ticking until the next command
        send_item(CMD_VEL, -16'sd900, 16'sd500, -16'sd1500);
        send_item(CMD_STOP, 16'd0, 16'd0, 16'd0);
        send_item(CMD_TICK, 16'd0, 16'd0, 16'd0);
        send_item(CMD_VEL, -16'sd1, 16'sd3, -16'sd3);
        repeat (2) send_item(CMD_TICK, 16'd0, 16'd0, 16'd0);
        wait_idle();
    endtask

    // register extremes, lateral gating and zero limits
    task automatic test_register_extremes();
        apply_config(32767, 32767, 32767, 255, 65535, 1, 1000);
        send_item(CMD_VEL, 16'h7FFF, 16'h8000, 16'sd12345);
        send_item(CMD_VEL, 16'h8000, 16'h7FFF, 16'h8000);
        vel_then_ticks(2, 3);
        send_item(CMD_STOP, 16'd0, 16'd0, 16'd0);
        wait_idle();

        // every limit zero, lateral off, instant timeout, zero threshold
        apply_config(0, 0, 0, 0, 0, 0, 0);
        vel_then_ticks(3, 2);
        wait_idle();

        apply_config(500, 32767, 0, 128, 2, 0, 1000);
        vel_then_ticks(4, 6);
        wait_idle();

        apply_config(32767, 0, 32767, 1, 1, 1, 0);
        vel_then_ticks(2, 8);
        wait_idle();
    endtask

    // random settings every few dozen items, mostly well-formed sequences
    task automatic test_random_traffic();
        int               sent;
        int               next_cfg;
        int               nv;
        int               nt;
        logic [CMD_W-1:0] op;
        sent     = 0;
        next_cfg = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent >= next_cfg) begin
                wait_idle();
                apply_config(pick_setting(32767, 3000), pick_setting(32767, 3000),
                             pick_setting(32767, 3000), pick_setting(255, 255),
                             pick_setting(65535, 6), $urandom_range(0, 1),
                             pick_setting(1000, 300));
                next_cfg = sent + $urandom_range(30, 60);
            end
            case ($urandom_range(0, 9))
                0: begin
                    // stop, then ticks that must be ignored
                    nt = $urandom_range(0, 3);
                    send_item(CMD_STOP, 16'($urandom()), 16'($urandom()), 16'($urandom()));
                    repeat (nt) send_item(CMD_TICK, 16'($urandom()), 16'd0, 16'd0);
                    sent += 1 + nt;
                end
                1: begin
                    // noise, unused code included
                    op = CMD_W'($urandom_range(0, 3));
                    send_item(op, 16'($urandom()), 16'($urandom()), 16'($urandom()));
                    if (op != CMD_UNUSED) sent++;
                end
                default: begin
                    nv = $urandom_range(1, 4);
                    nt = $urandom_range(0, (cfg_timeout < 8) ? cfg_timeout + 8 : 4);
                    vel_then_ticks(nv, nt);
                    sent += nv + nt;
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // sequence of the run
    // ------------------------------------------------------------------

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_edges();
        test_decay_and_threshold();
        test_register_extremes();
        test_random_traffic();

        wait_idle();
        if (mismatches == 0) begin
            $display("omni_velocity_shaper_framer_tb: done, clean");
        end else begin
            $display("omni_velocity_shaper_framer_tb: done, errors");
        end
        $finish;
    end

endmodule
